[rtl/core/dclk_pkg.sv]
package dclk_pkg;

   localparam int CODE_LENGTH = 4;
   localparam int POS_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
   localparam int DIGIT_W = 4;
   localparam int JOY_W = 12;
   localparam int LEVEL_W = 14;
   localparam int EVENT_W = 4;
   localparam int INDEX_W = 2;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_THR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_THR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OPEN_LEVEL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_LEVEL = 2'd3;

   localparam logic [JOY_W-1:0] LEFT_THR_RST = JOY_W'((4096 / 2) - 200);
   localparam logic [JOY_W-1:0] RIGHT_THR_RST = JOY_W'((4096 / 2) + 200);
   localparam logic [LEVEL_W-1:0] OPEN_LEVEL_RST = LEVEL_W'(220);
   localparam logic [LEVEL_W-1:0] CLOSE_LEVEL_RST = LEVEL_W'(1100);

   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(CODE_LENGTH - 1);

   localparam logic [EVENT_W-1:0] EV_NONE = 4'd0;
   localparam logic [EVENT_W-1:0] EV_TAKEN = 4'd1;
   localparam logic [EVENT_W-1:0] EV_DELETED = 4'd2;
   localparam logic [EVENT_W-1:0] EV_REFUSED = 4'd3;
   localparam logic [EVENT_W-1:0] EV_CORRECT = 4'd4;
   localparam logic [EVENT_W-1:0] EV_WRONG = 4'd5;
   localparam logic [EVENT_W-1:0] EV_CHANGED = 4'd6;
   localparam logic [EVENT_W-1:0] EV_CHANGE_MODE = 4'd7;
   localparam logic [EVENT_W-1:0] EV_CLOSED = 4'd8;

   typedef struct packed {
      logic              button_a_pressed;
      logic              button_b_pressed;
      logic [JOY_W-1:0]  joy_sample;
   } req_word_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] shown_digit;
      logic [INDEX_W-1:0] entry_index;
      logic               is_open;
      logic               in_change_mode;
      logic [LEVEL_W-1:0] servo_level;
      logic [EVENT_W-1:0] event_code;
   } rsp_word_type;

   typedef struct packed {
      logic [JOY_W-1:0]   left_threshold;
      logic [JOY_W-1:0]   right_threshold;
      logic [LEVEL_W-1:0] open_pulse_level;
      logic [LEVEL_W-1:0] close_pulse_level;
   } cfg_type;

endpackage

[rtl/core/digit_code_lock_controller.sv]
// channel | direction | handshake           | word
// req     | in        | req_valid/req_stall | req_data: buttons A, B, joystick sample
// rsp     | out       | rsp_valid/rsp_stall | rsp_data: digit, index, lock state, servo, event
// csr     | in        | csr_wr_en           | csr_index, csr_wdata (no read-back)
//
// One word per cycle sustained while rsp is not stalled; a word goes to rsp through
// the input register, then the result register (the lock update sits between them).
// Reset is synchronous and active high; it restores the register defaults and a
// closed lock with a zero code.
// A stalled rsp holds its word; req stalls only while both stages are full.
module digit_code_lock_controller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  dclk_pkg::req_word_type          req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output dclk_pkg::rsp_word_type          rsp_data,
   input  logic                            csr_wr_en,
   input  logic [dclk_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dclk_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic                   in_valid_ff;
   dclk_pkg::req_word_type in_word_ff;
   logic                   out_valid_ff;
   dclk_pkg::rsp_word_type out_word_ff;
   dclk_pkg::rsp_word_type next_word;
   dclk_pkg::cfg_type      cfg;
   logic                   advance;
   logic                   take;

   assign advance = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take = req_valid && !req_stall;

   dclk_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dclk_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .req_word (in_word_ff),
      .cfg      (cfg),
      .rsp_word (next_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_word_ff <= req_data;
      end
      if (advance) begin
         out_word_ff <= next_word;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_word_ff;

`ifndef SYNTH
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.shown_digit <= dclk_pkg::DIGIT_MAX)
      else $error("shown digit above nine");

   a_change_needs_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.in_change_mode |-> rsp_data.is_open)
      else $error("change mode while lock closed");

   a_servo_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_code != dclk_pkg::EV_CORRECT
      && rsp_data.event_code != dclk_pkg::EV_CHANGED
      && rsp_data.event_code != dclk_pkg::EV_CLOSED
      |-> rsp_data.servo_level == '0)
      else $error("servo moved without open or close");

   a_correct_opens: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_code == dclk_pkg::EV_CORRECT
      |-> rsp_data.is_open && rsp_data.entry_index == '0)
      else $error("correct code left lock closed or index nonzero");
`endif

endmodule

[rtl/core/dclk_csr.sv]
module dclk_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [dclk_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dclk_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output dclk_pkg::cfg_type                  cfg
);

   dclk_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_threshold <= dclk_pkg::LEFT_THR_RST;
         cfg_ff.right_threshold <= dclk_pkg::RIGHT_THR_RST;
         cfg_ff.open_pulse_level <= dclk_pkg::OPEN_LEVEL_RST;
         cfg_ff.close_pulse_level <= dclk_pkg::CLOSE_LEVEL_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            dclk_pkg::CSR_LEFT_THR: begin
               cfg_ff.left_threshold <= csr_wdata[dclk_pkg::JOY_W-1:0];
            end
            dclk_pkg::CSR_RIGHT_THR: begin
               cfg_ff.right_threshold <= csr_wdata[dclk_pkg::JOY_W-1:0];
            end
            dclk_pkg::CSR_OPEN_LEVEL: begin
               cfg_ff.open_pulse_level <= csr_wdata[dclk_pkg::LEVEL_W-1:0];
            end
            dclk_pkg::CSR_CLOSE_LEVEL: begin
               cfg_ff.close_pulse_level <= csr_wdata[dclk_pkg::LEVEL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/dclk_core.sv]
module dclk_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  dclk_pkg::req_word_type  req_word,
   input  dclk_pkg::cfg_type       cfg,
   output dclk_pkg::rsp_word_type  rsp_word
);

   logic [dclk_pkg::CODE_LENGTH-1:0][dclk_pkg::DIGIT_W-1:0] stored_ff, stored_in;
   logic [dclk_pkg::CODE_LENGTH-1:0][dclk_pkg::DIGIT_W-1:0] entry_ff, entry_in;
   logic [dclk_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [dclk_pkg::DIGIT_W-1:0] digit_ff, digit_in;
   logic                         open_ff, open_in;
   logic                         chg_ff, chg_in;
   logic [dclk_pkg::LEVEL_W-1:0] servo;
   logic [dclk_pkg::EVENT_W-1:0] ev;
   logic [dclk_pkg::POS_W+1:0]   pos_ext;

   always_comb begin
      stored_in = stored_ff;
      entry_in = entry_ff;
      pos_in = pos_ff;
      digit_in = digit_ff;
      open_in = open_ff;
      chg_in = chg_ff;
      servo = '0;
      ev = dclk_pkg::EV_NONE;

      if (open_ff && !chg_ff) begin
         if (req_word.button_a_pressed) begin
            chg_in = 1'b1;
            ev = dclk_pkg::EV_CHANGE_MODE;
         end else if (req_word.button_b_pressed) begin
            open_in = 1'b0;
            servo = cfg.close_pulse_level;
            ev = dclk_pkg::EV_CLOSED;
         end
      end else if (req_word.button_b_pressed) begin
         if (pos_ff <= dclk_pkg::LAST_POS) begin
            entry_in[pos_ff] = digit_ff;
         end
         if (pos_ff >= dclk_pkg::LAST_POS) begin
            pos_in = '0;
            if (chg_ff) begin
               stored_in = entry_in;
               open_in = 1'b0;
               chg_in = 1'b0;
               servo = cfg.close_pulse_level;
               ev = dclk_pkg::EV_CHANGED;
            end else if (entry_in == stored_ff) begin
               open_in = 1'b1;
               servo = cfg.open_pulse_level;
               ev = dclk_pkg::EV_CORRECT;
            end else begin
               ev = dclk_pkg::EV_WRONG;
            end
         end else begin
            pos_in = pos_ff + 1'b1;
            ev = dclk_pkg::EV_TAKEN;
         end
      end else if (req_word.button_a_pressed) begin
         if (pos_ff == '0) begin
            ev = dclk_pkg::EV_REFUSED;
         end else begin
            pos_in = pos_ff - 1'b1;
            ev = dclk_pkg::EV_DELETED;
         end
      end

      // low side wins when thresholds overlap
      if (req_word.joy_sample < cfg.left_threshold) begin
         digit_in = (digit_ff == '0) ? dclk_pkg::DIGIT_MAX : digit_ff - 1'b1;
      end else if (req_word.joy_sample > cfg.right_threshold) begin
         digit_in = (digit_ff >= dclk_pkg::DIGIT_MAX) ? '0 : digit_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff <= '0;
         entry_ff <= '0;
         pos_ff <= '0;
         digit_ff <= '0;
         open_ff <= 1'b0;
         chg_ff <= 1'b0;
      end else if (step) begin
         stored_ff <= stored_in;
         entry_ff <= entry_in;
         pos_ff <= pos_in;
         digit_ff <= digit_in;
         open_ff <= open_in;
         chg_ff <= chg_in;
      end
   end

   assign pos_ext = {2'b00, pos_in};

   always_comb begin
      rsp_word.shown_digit = digit_in;
      rsp_word.entry_index = pos_ext[dclk_pkg::INDEX_W-1:0];
      rsp_word.is_open = open_in;
      rsp_word.in_change_mode = chg_in;
      rsp_word.servo_level = servo;
      rsp_word.event_code = ev;
   end

endmodule

[dv/digit_code_lock_controller_test.sv]
`timescale 1ns / 1ps

import dclk_pkg::*;

class lock_scoreboard;
   logic [DIGIT_W-1:0] code_digits [CODE_LENGTH];
   logic [DIGIT_W-1:0] entered_digits [CODE_LENGTH];
   int                 position;
   logic [DIGIT_W-1:0] digit;
   bit                 unlocked;
   bit                 changing;
   logic [JOY_W-1:0]   left_thr;
   logic [JOY_W-1:0]   right_thr;
   logic [LEVEL_W-1:0] open_level;
   logic [LEVEL_W-1:0] close_level;
   rsp_word_type       expected_passes [$];
   int                 failures;

   function new();
      for (int i = 0; i < CODE_LENGTH; i++) begin
         code_digits[i] = '0;
         entered_digits[i] = '0;
      end
      position = 0;
      digit = '0;
      unlocked = 0;
      changing = 0;
      left_thr = LEFT_THR_RST;
      right_thr = RIGHT_THR_RST;
      open_level = OPEN_LEVEL_RST;
      close_level = CLOSE_LEVEL_RST;
      failures = 0;
   endfunction

   function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_LEFT_THR: left_thr = data[JOY_W-1:0];
         CSR_RIGHT_THR: right_thr = data[JOY_W-1:0];
         CSR_OPEN_LEVEL: open_level = data[LEVEL_W-1:0];
         CSR_CLOSE_LEVEL: close_level = data[LEVEL_W-1:0];
         default: ;
      endcase
   endfunction

   function int pending();
      return expected_passes.size();
   endfunction

   function void note_poll(req_word_type w);
      rsp_word_type       r;
      logic [LEVEL_W-1:0] servo;
      logic [EVENT_W-1:0] ev;
      bit                 same;
      servo = '0;
      ev = EV_NONE;
      if (unlocked && !changing) begin
         if (w.button_a_pressed) begin
            changing = 1;
            ev = EV_CHANGE_MODE;
         end else if (w.button_b_pressed) begin
            unlocked = 0;
            servo = close_level;
            ev = EV_CLOSED;
         end
      end else if (w.button_b_pressed) begin
         entered_digits[position] = digit;
         if (position == CODE_LENGTH - 1) begin
            position = 0;
            if (changing) begin
               for (int i = 0; i < CODE_LENGTH; i++) code_digits[i] = entered_digits[i];
               unlocked = 0;
               changing = 0;
               servo = close_level;
               ev = EV_CHANGED;
            end else begin
               same = 1;
               for (int i = 0; i < CODE_LENGTH; i++)
                  if (entered_digits[i] != code_digits[i]) same = 0;
               if (same) begin
                  unlocked = 1;
                  servo = open_level;
                  ev = EV_CORRECT;
               end else begin
                  ev = EV_WRONG;
               end
            end
         end else begin
            position++;
            ev = EV_TAKEN;
         end
      end else if (w.button_a_pressed) begin
         if (position == 0) begin
            ev = EV_REFUSED;
         end else begin
            position--;
            ev = EV_DELETED;
         end
      end

      if (w.joy_sample < left_thr)
         digit = (digit == 0) ? DIGIT_MAX : digit - 1'b1;
      else if (w.joy_sample > right_thr)
         digit = (digit >= DIGIT_MAX) ? '0 : digit + 1'b1;

      r.shown_digit = digit;
      r.entry_index = INDEX_W'(position);
      r.is_open = unlocked;
      r.in_change_mode = changing;
      r.servo_level = servo;
      r.event_code = ev;
      expected_passes.push_back(r);
   endfunction

   function void check_result(rsp_word_type got);
      rsp_word_type e;
      if (expected_passes.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("%0t unexpected word: digit %0d idx %0d open %0d chg %0d servo %0d ev %0d",
                     $realtime, got.shown_digit, got.entry_index, got.is_open,
                     got.in_change_mode, got.servo_level, got.event_code);
         return;
      end
      e = expected_passes.pop_front();
      if (got.shown_digit !== e.shown_digit || got.entry_index !== e.entry_index ||
          got.is_open !== e.is_open || got.in_change_mode !== e.in_change_mode ||
          got.servo_level !== e.servo_level || got.event_code !== e.event_code) begin
         failures++;
         if (failures <= 10)
            $display("%0t mismatch: exp digit %0d idx %0d open %0d chg %0d servo %0d ev %0d, got digit %0d idx %0d open %0d chg %0d servo %0d ev %0d",
                     $realtime, e.shown_digit, e.entry_index, e.is_open, e.in_change_mode,
                     e.servo_level, e.event_code, got.shown_digit, got.entry_index,
                     got.is_open, got.in_change_mode, got.servo_level, got.event_code);
      end
   endfunction
endclass

module digit_code_lock_controller_test;

   localparam int IDLE_LIMIT = 3000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_word_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_word_type          rsp_data;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lock_scoreboard sb = new();
   bit calm;
   int hold_left;
   int idle_cycles;
   int sent;

   digit_code_lock_controller dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // receiver: random stalls plus long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (!calm && $urandom_range(99) < 29) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_poll(bit a, bit b, logic [JOY_W-1:0] joy);
      req_word_type w;
      w.button_a_pressed = a;
      w.button_b_pressed = b;
      w.joy_sample = joy;
      if (!calm && $urandom_range(99) < 20) begin
         repeat ($urandom_range(3, 1)) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      sb.note_poll(w);
      sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_register(idx, data);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_config(int left, int right, int open_lvl, int close_lvl);
      drain();
      write_reg(CSR_LEFT_THR, CSR_DATA_W'(left));
      write_reg(CSR_RIGHT_THR, CSR_DATA_W'(right));
      write_reg(CSR_OPEN_LEVEL, CSR_DATA_W'(open_lvl));
      write_reg(CSR_CLOSE_LEVEL, CSR_DATA_W'(close_lvl));
   endtask

   function automatic logic [JOY_W-1:0] rand_joy();
      int pick;
      pick = $urandom_range(99);
      if (pick < 20) return '0;
      if (pick < 40) return '1;
      if (pick < 55) return JOY_W'(int'(sb.left_thr) + $urandom_range(2) - 1);
      if (pick < 70) return JOY_W'(int'(sb.right_thr) + $urandom_range(2) - 1);
      return JOY_W'($urandom_range(4095));
   endfunction

   task automatic dial(logic [DIGIT_W-1:0] target);
      int lo_up;
      bit can_down;
      bit can_up;
      bit go_down;
      lo_up = (int'(sb.right_thr) + 1 > int'(sb.left_thr)) ? int'(sb.right_thr) + 1
                                                            : int'(sb.left_thr);
      can_down = sb.left_thr != 0;
      can_up = lo_up <= 4095;
      if (!can_down && !can_up) return;
      go_down = can_down && (!can_up || $urandom_range(1));
      while (sb.digit != target) begin
         if (go_down)
            send_poll(0, 0, JOY_W'($urandom_range(int'(sb.left_thr) - 1, 0)));
         else
            send_poll(0, 0, JOY_W'($urandom_range(4095, lo_up)));
      end
   endtask

   task automatic enter_code(bit spoil);
      int bad;
      logic [DIGIT_W-1:0] d;
      bad = spoil ? $urandom_range(CODE_LENGTH - 1) : -1;
      while (sb.position != 0) send_poll(1, 0, rand_joy());
      for (int i = 0; i < CODE_LENGTH; i++) begin
         d = (i == bad) ? DIGIT_W'($urandom_range(9)) : sb.code_digits[i];
         dial(d);
         send_poll($urandom_range(1), 1, rand_joy());
      end
   endtask

   task automatic try_unlock(bit spoil);
      if (sb.unlocked && !sb.changing) send_poll(0, 1, rand_joy());
      enter_code(spoil);
   endtask

   task automatic change_code();
      try_unlock(0);
      if (sb.unlocked && !sb.changing) send_poll(1, $urandom_range(1), rand_joy());
      for (int i = 0; i < CODE_LENGTH; i++) begin
         dial(DIGIT_W'($urandom_range(9)));
         send_poll($urandom_range(1), 1, rand_joy());
      end
   endtask

   task automatic run_random(int count);
      int start;
      int pick;
      start = sent;
      while (sent - start < count) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            try_unlock($urandom_range(99) < 25);
         end else if (pick < 65) begin
            change_code();
         end else begin
            repeat ($urandom_range(8, 1)) begin
               send_poll($urandom_range(1), $urandom_range(1), rand_joy());
            end
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      calm = 1'b1;
      hold_left = 0;
      sent = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset settings, code 0000
      send_poll(0, 0, 12'd0);       // wrap down
      send_poll(0, 0, 12'd4095);    // wrap up
      send_poll(1, 0, 12'd2048);    // delete refused
      send_poll(1, 1, 12'd2048);    // B wins while closed
      send_poll(1, 0, 12'd2048);    // deleted
      repeat (CODE_LENGTH) send_poll(0, 1, 12'd2048);
      send_poll(0, 0, 12'd2048);
      send_poll(0, 1, 12'd2048);    // close
      repeat (CODE_LENGTH - 1) send_poll(0, 1, 12'd2048);
      send_poll(0, 0, 12'd4095);
      send_poll(0, 1, 12'd2048);    // wrong
      send_poll(0, 0, 12'd0);
      repeat (CODE_LENGTH) send_poll(0, 1, 12'd2048);
      send_poll(1, 1, 12'd2048);    // A wins while open
      send_poll(0, 1, 12'd4095);
      send_poll(0, 1, 12'd2048);
      send_poll(1, 1, 12'd0);
      send_poll(0, 1, 12'd2048);    // code changed
      send_poll(0, 0, 12'd1847);
      send_poll(0, 0, 12'd1848);
      send_poll(0, 0, 12'd2248);
      send_poll(0, 0, 12'd2249);

      run_random(90);
      calm = 1'b0;
      hold_left = 300;
      run_random(80);

      set_config($urandom_range(2000, 1000), $urandom_range(3500, 2100),
                 $urandom_range(10000), $urandom_range(10000));
      run_random(140);

      set_config(0, 4095, 0, 16383);
      run_random(100);

      set_config(4095, 0, 10000, 0);
      run_random(140);

      set_config(4095, 4095, 16383, 10000);
      run_random(110);

      set_config($urandom_range(4095), $urandom_range(4095),
                 $urandom_range(16383), $urandom_range(16383));
      run_random(140);

      set_config(int'(LEFT_THR_RST), int'(RIGHT_THR_RST),
                 int'(OPEN_LEVEL_RST), int'(CLOSE_LEVEL_RST));
      run_random(100);

      drain();
      repeat (10) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/dclk_pkg.sv
rtl/core/dclk_csr.sv
rtl/core/dclk_core.sv
rtl/core/digit_code_lock_controller.sv
dv/digit_code_lock_controller_test.sv
